// ----- rtl/maze_row_generator_macros.svh -----
// Assertion macros shared by the checker files of the maze row generator.
// Each macro expands to one labeled concurrent assertion; no other dependencies.
`ifndef MAZE_ROW_GENERATOR_MACROS_SVH
`define MAZE_ROW_GENERATOR_MACROS_SVH

// Same-cycle implication under reset.
`define MRG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under reset.
`define MRG_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/mrg_pkg.sv -----
// Package of the maze row generator: widths, register codes, microcode format,
// the microcode program and the free-label search. No dependencies.
`default_nettype none

package mrg_pkg;

    localparam int COLS_DEF  = 32;
    localparam int LBL_W     = 5;
    localparam int RR_W      = 31;
    localparam int RB_W      = 32;
    localparam int WALL_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_RESET = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int TDATA_W   = 64;

    // register index, taken from paddr[2]
    localparam logic REG_COLS_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_RIGHT,
        OP_LAST,
        OP_BOT,
        OP_OPEN,
        OP_NEW,
        OP_RESTART
    } t_op;

    typedef enum logic [2:0] {
        C_IN,
        C_SCAN,
        C_NEXT,
        C_LAST,
        C_EMIT
    } t_cond;

    typedef logic [3:0] t_pc;

    localparam t_pc PC_FETCH = 4'd0;
    localparam t_pc PC_RIGHT = 4'd1;
    localparam t_pc PC_TEST  = 4'd2;
    localparam t_pc PC_BOT   = 4'd3;
    localparam t_pc PC_OPEN  = 4'd4;
    localparam t_pc PC_NEW   = 4'd5;
    localparam t_pc PC_EMIT  = 4'd6;
    localparam t_pc PC_MERGE = 4'd7;
    localparam t_pc PC_CLEAR = 4'd8;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic load;
        logic shift;
        logic lab_rst;
        logic col_ok;
        logic pair_ok;
        logic col_end;
    } t_ring_ctl;

    function automatic t_uword uc_rom(input t_pc pc);
        t_uword w;
        unique case (pc)
            PC_FETCH: w = '{op: OP_NONE,    cond: C_IN,   target: PC_RIGHT};
            PC_RIGHT: w = '{op: OP_RIGHT,   cond: C_SCAN, target: PC_TEST};
            PC_TEST:  w = '{op: OP_NONE,    cond: C_LAST, target: PC_MERGE};
            PC_BOT:   w = '{op: OP_BOT,     cond: C_SCAN, target: PC_OPEN};
            PC_OPEN:  w = '{op: OP_OPEN,    cond: C_SCAN, target: PC_NEW};
            PC_NEW:   w = '{op: OP_NEW,     cond: C_SCAN, target: PC_EMIT};
            PC_EMIT:  w = '{op: OP_NONE,    cond: C_EMIT, target: PC_FETCH};
            PC_MERGE: w = '{op: OP_LAST,    cond: C_SCAN, target: PC_CLEAR};
            PC_CLEAR: w = '{op: OP_RESTART, cond: C_NEXT, target: PC_EMIT};
            default:  w = '{op: OP_NONE,    cond: C_IN,   target: PC_FETCH};
        endcase
        return w;
    endfunction

    // lowest clear bit; all ones gives the top label
    function automatic logic [LBL_W-1:0] first_free(input logic [(1 << LBL_W)-1:0] used);
        logic [LBL_W-1:0] res;
        res = LBL_W'((1 << LBL_W) - 1);
        for (int i = (1 << LBL_W) - 2; i >= 0; i--) begin
            if (!used[i]) begin
                res = LBL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/mrg_ring.sv -----
// Row of column cells of the maze row generator: set labels, random bits and walls,
// rotated one column per scan step with parallel label compares. Uses mrg_pkg.
`default_nettype none

module mrg_ring import mrg_pkg::*; #(
    parameter int COLS = COLS_DEF,
    parameter int NW   = $clog2(COLS + 1)
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ring_ctl         i_ctl,
    input  wire logic [NW-1:0]     i_n,
    input  wire logic [RR_W-1:0]   i_rnd_r,
    input  wire logic [RB_W-1:0]   i_rnd_b,
    output logic      [COLS-1:0]   o_right,
    output logic      [COLS-1:0]   o_bottom
);

    logic [LBL_W-1:0] r_lab [COLS];
    logic [LBL_W-1:0] m_lab [COLS];
    logic [LBL_W-1:0] n_lab [COLS];

    logic [COLS-1:0] r_act, r_rr, r_rb, r_rw, r_bw;
    logic [COLS-1:0] n_act, n_rr, n_rb, n_rw, n_bw;
    logic [COLS-1:0] m_rw, m_bw;
    logic [COLS-1:0] w_same_a, w_same_b;
    logic [(1 << LBL_W)-1:0] w_used;
    logic [RR_W:0]    w_rnd_r_ext;
    logic [LBL_W-1:0] w_a, w_b;
    logic             w_other, w_open;

    assign w_rnd_r_ext = {1'b0, i_rnd_r};
    assign w_a = r_lab[0];
    assign w_b = r_lab[1];

    always_comb begin
        w_used = '0;
        for (int p = 0; p < COLS; p++) begin
            w_same_a[p] = r_act[p] && (r_lab[p] == w_a);
            w_same_b[p] = r_act[p] && (r_lab[p] == w_b);
        end
        for (int p = 1; p < COLS; p++) begin
            if (r_act[p]) begin
                w_used[r_lab[p]] = 1'b1;
            end
        end
        w_other = |w_same_a[COLS-1:1];
        w_open  = |(w_same_a & ~r_bw);
    end

    always_comb begin
        m_lab = r_lab;
        m_rw  = r_rw;
        m_bw  = r_bw;
        unique case (i_ctl.op)
            OP_NONE: begin
            end
            OP_RIGHT: begin
                if (i_ctl.pair_ok) begin
                    if (r_rr[0] || (w_a == w_b)) begin
                        m_rw[0] = 1'b1;
                    end else begin
                        for (int p = 0; p < COLS; p++) begin
                            if (w_same_b[p]) begin
                                m_lab[p] = w_a;
                            end
                        end
                    end
                end
                if (i_ctl.col_end) begin
                    m_rw[0] = 1'b1;
                end
            end
            OP_LAST: begin
                if (i_ctl.pair_ok && (w_a != w_b)) begin
                    m_rw[0] = 1'b0;
                    for (int p = 0; p < COLS; p++) begin
                        if (w_same_b[p]) begin
                            m_lab[p] = w_a;
                        end
                    end
                end
            end
            OP_BOT: begin
                if (i_ctl.col_ok && r_rb[0] && w_other) begin
                    m_bw[0] = 1'b1;
                end
            end
            OP_OPEN: begin
                if (i_ctl.col_ok && !w_open) begin
                    m_bw[0] = 1'b0;
                end
            end
            OP_NEW: begin
                if (i_ctl.col_ok && r_bw[0]) begin
                    m_lab[0] = first_free(w_used);
                end
            end
            OP_RESTART: begin
                m_bw = r_act;
                for (int p = 0; p < COLS; p++) begin
                    m_lab[p] = LBL_W'(p);
                end
            end
            default: begin
            end
        endcase
        if (i_ctl.lab_rst) begin
            for (int p = 0; p < COLS; p++) begin
                m_lab[p] = LBL_W'(p);
            end
        end
    end

    always_comb begin
        n_lab = m_lab;
        n_act = r_act;
        n_rr  = r_rr;
        n_rb  = r_rb;
        n_rw  = m_rw;
        n_bw  = m_bw;
        if (i_ctl.shift) begin
            for (int p = 0; p < COLS - 1; p++) begin
                n_lab[p] = m_lab[p+1];
            end
            n_lab[COLS-1] = m_lab[0];
            n_act = {r_act[0], r_act[COLS-1:1]};
            n_rr  = {r_rr[0],  r_rr[COLS-1:1]};
            n_rb  = {r_rb[0],  r_rb[COLS-1:1]};
            n_rw  = {m_rw[0],  m_rw[COLS-1:1]};
            n_bw  = {m_bw[0],  m_bw[COLS-1:1]};
        end
        if (i_ctl.load) begin
            for (int p = 0; p < COLS; p++) begin
                n_act[p] = NW'(p) < i_n;
                n_rr[p]  = w_rnd_r_ext[p];
                n_rb[p]  = i_rnd_b[p];
            end
            n_rw = '0;
            n_bw = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < COLS; p++) begin
                r_lab[p] <= LBL_W'(p);
            end
            r_act <= '0;
            r_rr  <= '0;
            r_rb  <= '0;
            r_rw  <= '0;
            r_bw  <= '0;
        end else begin
            r_lab <= n_lab;
            r_act <= n_act;
            r_rr  <= n_rr;
            r_rb  <= n_rb;
            r_rw  <= n_rw;
            r_bw  <= n_bw;
        end
    end

    assign o_right  = r_rw;
    assign o_bottom = r_bw;

endmodule

`default_nettype wire

// ----- rtl/maze_row_generator.sv -----
// Maze row generator top level: microcode sequencer, APB register, stream ports.
// Depends on mrg_pkg and mrg_ring.
//
// Usage: one row of a maze per input transaction on the s_axis side. tdata carries
// the right-wall random bits and the bottom-wall random bits, tlast marks the last
// row of a maze. Each row gives one output transaction on the m_axis side with the
// right and bottom walls of its cells; tlast echoes the last-row mark.
// A microcoded sequencer runs passes over the row of cells; each pass rotates the
// row once, one column per cycle.
// Regular row: right-wall, bottom-wall, opening and new-label passes; last row:
// right-wall and merge passes, then a label restart, before the result is written.
// The result sits in an output register; the block takes the next row while it
// waits. If the receiver stalls, the sequencer holds before writing the next result.
// cols_in_use (address 0) sets the column count; a write restarts the labels, so a
// new maze begins. Write it only while idle.
// Reset: cols_in_use is 32, labels return to their column index, nothing is pending.
`default_nettype none

module maze_row_generator import mrg_pkg::*; #(
    parameter int COLS = COLS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [ADDR_W-1:0]  paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic      [DATA_W-1:0]  prdata,
    output logic                    pready,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [30:0] right_random, [62:31] bottom_random, [63] zero
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    input  wire logic               s_axis_tlast,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [31:0] right_walls, [63:32] bottom_walls
    output logic      [TDATA_W-1:0] m_axis_tdata,
    output logic                    m_axis_tlast
);

    localparam int NW = $clog2(COLS + 1);
    localparam int CW = $clog2(COLS);

    t_pc             r_pc, n_pc;
    logic [CW-1:0]   r_col, n_col;
    logic [CFG_W-1:0] r_cols;
    logic            r_last;
    logic            r_out_valid;
    logic [WALL_W-1:0] r_out_right, r_out_bottom;
    logic            r_out_last;

    t_uword          w_uw;
    t_ring_ctl       w_ctl;
    logic [NW-1:0]   w_n;
    logic            w_cfg_wr;
    logic            w_emit;
    logic [COLS-1:0] w_right, w_bottom;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COLS_IN_USE);
    assign prdata   = (paddr[2] == REG_COLS_IN_USE) ? DATA_W'(r_cols) : '0;

    always_comb begin
        if (r_cols == '0) begin
            w_n = NW'(1);
        end else if (r_cols > CFG_W'(COLS)) begin
            w_n = NW'(COLS);
        end else begin
            w_n = NW'(r_cols);
        end
    end

    always_comb begin
        w_uw          = uc_rom(r_pc);
        n_pc          = r_pc;
        n_col         = r_col;
        w_emit        = 1'b0;
        w_ctl         = '0;
        w_ctl.op      = OP_NONE;
        w_ctl.lab_rst = w_cfg_wr;
        w_ctl.col_ok  = NW'(r_col) < w_n;
        w_ctl.pair_ok = (NW'(r_col) + NW'(1)) < w_n;
        w_ctl.col_end = NW'(r_col) == (w_n - NW'(1));
        s_axis_tready = (w_uw.cond == C_IN);
        unique case (w_uw.cond)
            C_IN: begin
                if (s_axis_tvalid) begin
                    w_ctl.load = 1'b1;
                    n_pc       = w_uw.target;
                end
            end
            C_SCAN: begin
                w_ctl.op    = w_uw.op;
                w_ctl.shift = 1'b1;
                if (r_col == CW'(COLS - 1)) begin
                    n_col = '0;
                    n_pc  = w_uw.target;
                end else begin
                    n_col = r_col + CW'(1);
                end
            end
            C_NEXT: begin
                w_ctl.op = w_uw.op;
                n_pc     = w_uw.target;
            end
            C_LAST: begin
                n_pc = r_last ? w_uw.target : (r_pc + t_pc'(1));
            end
            C_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_emit = 1'b1;
                    n_pc   = w_uw.target;
                end
            end
            default: begin
            end
        endcase
    end

    mrg_ring #(
        .COLS (COLS),
        .NW   (NW)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_n      (w_n),
        .i_rnd_r  (s_axis_tdata[RR_W-1:0]),
        .i_rnd_b  (s_axis_tdata[RR_W+RB_W-1:RR_W]),
        .o_right  (w_right),
        .o_bottom (w_bottom)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_FETCH;
            r_col       <= '0;
            r_cols      <= CFG_W'(CFG_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_col <= n_col;
            if (w_cfg_wr) begin
                r_cols <= pwdata[CFG_W-1:0];
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_last <= s_axis_tlast;
        end
        if (w_emit) begin
            r_out_right  <= WALL_W'(w_right);
            r_out_bottom <= WALL_W'(w_bottom);
            r_out_last   <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_bottom, r_out_right};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ----- rtl/mrg_chk.sv -----
// Port-level checker of the maze row generator, bound to the top level.
// Depends on mrg_pkg and maze_row_generator_macros.svh.
`default_nettype none
`include "maze_row_generator_macros.svh"

module mrg_chk import mrg_pkg::*; #(
    parameter int COLS = COLS_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               psel,
    input wire logic               penable,
    input wire logic               pwrite,
    input wire logic               pready,
    input wire logic [ADDR_W-1:0]  paddr,
    input wire logic [DATA_W-1:0]  pwdata,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic               m_axis_tlast
);

    logic [CFG_W-1:0]  r_cols;
    logic [CFG_W-1:0]  w_n;
    logic [WALL_W-1:0] w_mask, w_top, w_right, w_bot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= CFG_W'(CFG_RESET);
        end else if (psel && penable && pwrite && pready
                     && (paddr[2] == REG_COLS_IN_USE)) begin
            r_cols <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        if (r_cols == '0) begin
            w_n = CFG_W'(1);
        end else if (r_cols > CFG_W'(COLS)) begin
            w_n = CFG_W'(COLS);
        end else begin
            w_n = r_cols;
        end
        w_mask = (w_n >= CFG_W'(WALL_W)) ? '1 : ((WALL_W'(1) << w_n) - WALL_W'(1));
        w_top  = WALL_W'(1) << (w_n - CFG_W'(1));
    end

    assign w_right = m_axis_tdata[WALL_W-1:0];
    assign w_bot   = m_axis_tdata[2*WALL_W-1:WALL_W];

    `MRG_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result changed while stalled")
    `MRG_ASSERT_IMP(a_cols_bound, i_clk, i_rst_n, m_axis_tvalid, ((w_right & ~w_mask) == '0) && ((w_bot & ~w_mask) == '0) && ((w_right & w_top) != '0), "walls outside active columns or missing edge wall")
    `MRG_ASSERT_IMP(a_opening, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast, (w_bot & w_mask) != w_mask, "row without any downward opening")
    `MRG_ASSERT_IMP(a_last_floor, i_clk, i_rst_n, m_axis_tvalid && m_axis_tlast, w_bot == w_mask, "last row not fully walled at the bottom")

endmodule

bind maze_row_generator mrg_chk #(.COLS(COLS)) u_mrg_chk (.*);

`default_nettype wire
